[design/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define IRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition never holds outside reset
`define IRM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[design/irm_pkg.sv]
`default_nettype none

package irm_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int NUM_BUSES   = 6;

  localparam logic [7:0] RECOVERY_DEFAULT = 8'd100;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_WBYTE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_OP_IS_WRITE     = 3'd0,
    REG_BUS_SELECT      = 3'd1,
    REG_DEVICE_ADDRESS  = 3'd2,
    REG_REGISTER_ADDR   = 3'd3,
    REG_BYTE_COUNT      = 3'd4,
    REG_RECOVERY_LIMIT  = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RST_SCL, ST_RST_SDA, ST_RST_REL, ST_RST_CHECK, ST_RST_HIGH,
    ST_START_SDA, ST_START_SCL, ST_BIT_SDA, ST_BIT_HI, ST_BIT_LO,
    ST_ACK_REL, ST_ACK_SDA, ST_ACK_HI, ST_ACK_SAMPLE, ST_ACK_OK, ST_ACK_FAIL,
    ST_WAIT_BYTE, ST_REP_SDA1, ST_REP_SCL1, ST_REP_SDA0, ST_REP_SCL0,
    ST_IN_REL, ST_IN_SDA, ST_IN_HI, ST_IN_SAMPLE, ST_IN_DRIVE,
    ST_STOP_SDA, ST_STOP_SCL, ST_STOP_END
  } step_e;

  typedef enum logic [1:0] {
    ROLE_DEV, ROLE_REG, ROLE_WDATA, ROLE_RADDR
  } role_e;

  typedef struct packed {
    logic       op_is_write;
    logic [2:0] bus_select;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] recovery_pulse_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       sda_sample;
    logic [7:0] write_byte;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       drive_enable;
    logic [2:0] target_bus;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_write_byte;
    logic       busy_res;
    logic       done_res;
    logic       no_ack_error;
  } res_t;

endpackage

`default_nettype wire

[design/irm_req_if.sv]
`default_nettype none

interface irm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       sda_sample;
  logic [7:0] write_byte;

  modport source (output valid, output kind, output sda_sample, output write_byte,
                  input ready);
  modport sink (input valid, input kind, input sda_sample, input write_byte,
                output ready);
endinterface

`default_nettype wire

[design/irm_res_if.sv]
`default_nettype none

interface irm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       drive_enable;
  logic [2:0] target_bus;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       need_write_byte;
  logic       busy_res;
  logic       done_res;
  logic       no_ack_error;

  modport source (output valid, output scl_level, output sda_level, output drive_enable,
                  output target_bus, output read_byte, output read_valid,
                  output need_write_byte, output busy_res, output done_res,
                  output no_ack_error, input ready);
  modport sink (input valid, input scl_level, input sda_level, input drive_enable,
                input target_bus, input read_byte, input read_valid,
                input need_write_byte, input busy_res, input done_res,
                input no_ack_error, output ready);
endinterface

`default_nettype wire

[design/irm_cfg_if.sv]
`default_nettype none

interface irm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/irm_seq.sv]
`default_nettype none
`include "assert_macros.svh"

module irm_seq
  import irm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_en_i,
  input  req_t      req_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  localparam int CmpW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  step_e                  step_q, step_d;
  role_e                  role_q, role_d;
  cfg_t                   lat_q, lat_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             bytes_q, bytes_d;
  logic [7:0]             shift_q, shift_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   oe_q, oe_d;
  logic [COUNT_WIDTH-1:0] rec_q, rec_d;
  logic [7:0]             held_q, held_d;
  logic                   have_q, have_d;
  logic                   rvalid, done, err;
  logic [7:0]             ack_bytes;
  logic [CmpW-1:0]        rec_ext, lim_ext;

  assign rec_ext = CmpW'(rec_q);
  assign lim_ext = CmpW'(lat_q.recovery_pulse_limit);
  assign ack_bytes = (role_q == ROLE_WDATA) ? bytes_q + 8'd1 : bytes_q;

  // next state
  always_comb begin
    step_d  = step_q;
    role_d  = role_q;
    lat_d   = lat_q;
    bit_d   = bit_q;
    bytes_d = bytes_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    oe_d    = oe_q;
    rec_d   = rec_q;
    held_d  = held_q;
    have_d  = have_q;
    rvalid  = 1'b0;
    done    = 1'b0;
    err     = 1'b0;
    case (req_i.kind)
      KIND_START: begin
        if (step_q == ST_IDLE && int'(cfg_i.bus_select) < NUM_BUSES) begin
          lat_d   = cfg_i;
          bytes_d = '0;
          rec_d   = '0;
          bit_d   = '0;
          oe_d    = 1'b1;
          step_d  = ST_RST_SCL;
        end
      end
      KIND_WBYTE: begin
        held_d = req_i.write_byte;
        have_d = 1'b1;
      end
      KIND_TICK: begin
        case (step_q)
          ST_RST_SCL: begin
            scl_d  = 1'b1;
            step_d = ST_RST_SDA;
          end
          ST_RST_SDA: begin
            sda_d  = 1'b1;
            step_d = ST_RST_REL;
          end
          ST_RST_REL: begin
            oe_d   = 1'b0;
            step_d = ST_RST_CHECK;
          end
          ST_RST_CHECK: begin
            if (!req_i.sda_sample && rec_ext < lim_ext && !(&rec_q)) begin
              scl_d  = 1'b0;
              rec_d  = rec_q + COUNT_WIDTH'(1);
              step_d = ST_RST_HIGH;
            end else begin
              oe_d   = 1'b1;
              step_d = ST_START_SDA;
            end
          end
          ST_RST_HIGH: begin
            scl_d  = 1'b1;
            step_d = ST_RST_CHECK;
          end
          ST_START_SDA: begin
            sda_d  = 1'b0;
            step_d = ST_START_SCL;
          end
          ST_START_SCL: begin
            scl_d   = 1'b0;
            shift_d = lat_q.device_address;
            bit_d   = 3'd7;
            role_d  = ROLE_DEV;
            step_d  = ST_BIT_SDA;
          end
          ST_BIT_SDA: begin
            sda_d  = shift_q[bit_q];
            step_d = ST_BIT_HI;
          end
          ST_BIT_HI: begin
            scl_d  = 1'b1;
            step_d = ST_BIT_LO;
          end
          ST_BIT_LO: begin
            scl_d = 1'b0;
            if (bit_q == 3'd0) begin
              step_d = ST_ACK_REL;
            end else begin
              bit_d  = bit_q - 3'd1;
              step_d = ST_BIT_SDA;
            end
          end
          ST_ACK_REL: begin
            oe_d   = 1'b0;
            step_d = ST_ACK_SDA;
          end
          ST_ACK_SDA: begin
            sda_d  = 1'b1;
            step_d = ST_ACK_HI;
          end
          ST_ACK_HI: begin
            scl_d  = 1'b1;
            step_d = ST_ACK_SAMPLE;
          end
          ST_ACK_SAMPLE: begin
            scl_d  = 1'b0;
            step_d = req_i.sda_sample ? ST_ACK_FAIL : ST_ACK_OK;
          end
          ST_ACK_OK: begin
            oe_d = 1'b1;
            case (role_q)
              ROLE_DEV: begin
                shift_d = lat_q.register_address;
                bit_d   = 3'd7;
                role_d  = ROLE_REG;
                step_d  = ST_BIT_SDA;
              end
              ROLE_RADDR: begin
                step_d = ST_IN_REL;
              end
              default: begin
                bytes_d = ack_bytes;
                if (ack_bytes >= lat_q.byte_count) begin
                  step_d = ST_STOP_SDA;
                end else if (lat_q.op_is_write) begin
                  step_d = ST_WAIT_BYTE;
                end else begin
                  step_d = ST_REP_SDA1;
                end
              end
            endcase
          end
          ST_ACK_FAIL: begin
            oe_d   = 1'b1;
            done   = 1'b1;
            err    = 1'b1;
            step_d = ST_IDLE;
          end
          ST_WAIT_BYTE: begin
            if (have_q) begin
              shift_d = held_q;
              bit_d   = 3'd7;
              role_d  = ROLE_WDATA;
              have_d  = 1'b0;
              sda_d   = held_q[7];
              step_d  = ST_BIT_HI;
            end
          end
          ST_REP_SDA1: begin
            sda_d  = 1'b1;
            step_d = ST_REP_SCL1;
          end
          ST_REP_SCL1: begin
            scl_d  = 1'b1;
            step_d = ST_REP_SDA0;
          end
          ST_REP_SDA0: begin
            sda_d  = 1'b0;
            step_d = ST_REP_SCL0;
          end
          ST_REP_SCL0: begin
            scl_d   = 1'b0;
            shift_d = lat_q.device_address | 8'd1;
            bit_d   = 3'd7;
            role_d  = ROLE_RADDR;
            step_d  = ST_BIT_SDA;
          end
          ST_IN_REL: begin
            oe_d   = 1'b0;
            step_d = ST_IN_SDA;
          end
          ST_IN_SDA: begin
            sda_d   = 1'b1;
            bit_d   = 3'd7;
            shift_d = '0;
            step_d  = ST_IN_HI;
          end
          ST_IN_HI: begin
            scl_d  = 1'b1;
            step_d = ST_IN_SAMPLE;
          end
          ST_IN_SAMPLE: begin
            if (req_i.sda_sample) begin
              shift_d[bit_q] = 1'b1;
            end
            scl_d = 1'b0;
            if (bit_q == 3'd0) begin
              step_d = ST_IN_DRIVE;
            end else begin
              bit_d  = bit_q - 3'd1;
              step_d = ST_IN_HI;
            end
          end
          ST_IN_DRIVE: begin
            oe_d    = 1'b1;
            rvalid  = 1'b1;
            bytes_d = bytes_q + 8'd1;
            step_d  = (bytes_d >= lat_q.byte_count) ? ST_STOP_SDA : ST_REP_SDA1;
          end
          ST_STOP_SDA: begin
            sda_d  = 1'b0;
            step_d = ST_STOP_SCL;
          end
          ST_STOP_SCL: begin
            scl_d  = 1'b1;
            step_d = ST_STOP_END;
          end
          ST_STOP_END: begin
            sda_d  = 1'b1;
            done   = 1'b1;
            step_d = ST_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res_o.scl_level       = scl_d;
    res_o.sda_level       = sda_d;
    res_o.drive_enable    = oe_d;
    res_o.target_bus      = lat_d.bus_select;
    res_o.read_byte       = rvalid ? shift_q : 8'd0;
    res_o.read_valid      = rvalid;
    res_o.need_write_byte = (step_d == ST_WAIT_BYTE) && !have_d;
    res_o.busy_res        = (step_d != ST_IDLE);
    res_o.done_res        = done;
    res_o.no_ack_error    = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      role_q  <= ROLE_DEV;
      lat_q   <= '0;
      bit_q   <= '0;
      bytes_q <= '0;
      shift_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b1;
      rec_q   <= '0;
      have_q  <= 1'b0;
    end else if (step_en_i) begin
      step_q  <= step_d;
      role_q  <= role_d;
      lat_q   <= lat_d;
      bit_q   <= bit_d;
      bytes_q <= bytes_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      rec_q   <= rec_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      held_q <= held_d;
    end
  end

  `IRM_ASSERT(a_idle_leaves_on_start, clk_i, rst_ni, (step_q == ST_IDLE) && !(step_en_i && req_i.kind == KIND_START) |=> step_q == ST_IDLE, "sequencer left idle without a start request")
  `IRM_ASSERT(a_recovery_in_limit, clk_i, rst_ni, rec_ext <= lim_ext, "recovery pulse count above its limit")

endmodule

`default_nettype wire

[design/i2c_register_access_master_top.sv]
// a request's result is registered and offered in the cycle after it is accepted
// throughput: one request per cycle while results are taken; every request gives exactly one result
// the only loop is the pin sequencer state, updated once per accepted request
// rst_ni clears the sequencer to idle with scl, sda and drive enable high
// configuration resets to zero but for the recovery pulse limit, which resets to 100
`default_nettype none
`include "assert_macros.svh"

module i2c_register_access_master_top
  import irm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  irm_cfg_if.sink   cfg_i,
  irm_req_if.sink   req_i,
  irm_res_if.source res_o
);

  cfg_t cfg_q;
  req_t req;
  res_t seq_res;
  res_t res_q;
  logic res_valid_q;
  logic step_en;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{recovery_pulse_limit: RECOVERY_DEFAULT, default: '0};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_OP_IS_WRITE:    cfg_q.op_is_write          <= cfg_i.data[0];
        REG_BUS_SELECT:     cfg_q.bus_select           <= cfg_i.data[2:0];
        REG_DEVICE_ADDRESS: cfg_q.device_address       <= cfg_i.data;
        REG_REGISTER_ADDR:  cfg_q.register_address     <= cfg_i.data;
        REG_BYTE_COUNT:     cfg_q.byte_count           <= cfg_i.data;
        REG_RECOVERY_LIMIT: cfg_q.recovery_pulse_limit <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign step_en     = req_i.valid && req_i.ready;

  assign req.kind       = req_i.kind;
  assign req.sda_sample = req_i.sda_sample;
  assign req.write_byte = req_i.write_byte;

  irm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .req_i     (req),
    .cfg_i     (cfg_q),
    .res_o     (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_en) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= seq_res;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.scl_level       = res_q.scl_level;
  assign res_o.sda_level       = res_q.sda_level;
  assign res_o.drive_enable    = res_q.drive_enable;
  assign res_o.target_bus      = res_q.target_bus;
  assign res_o.read_byte       = res_q.read_byte;
  assign res_o.read_valid      = res_q.read_valid;
  assign res_o.need_write_byte = res_q.need_write_byte;
  assign res_o.busy_res        = res_q.busy_res;
  assign res_o.done_res        = res_q.done_res;
  assign res_o.no_ack_error    = res_q.no_ack_error;

  `IRM_ASSERT(a_request_gives_result, clk_i, rst_ni, step_en |=> res_valid_q, "accepted request left no result")
  `IRM_NEVER(a_error_only_with_done, clk_i, rst_ni, res_valid_q && res_q.no_ack_error && !res_q.done_res, "ack error reported without done")

endmodule

`default_nettype wire

[test/tb_i2c_register_access_master_top.sv]
`timescale 1ns / 100ps

module tb_i2c_register_access_master_top;
  import irm_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int RUN_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    step_e      st;
    role_e      role;
    logic [2:0] bit_idx;
    logic [7:0] n_done;
    logic [7:0] shreg;
    logic [7:0] rec_cnt;
    logic [7:0] held;
    logic       have;
    logic       scl;
    logic       sda;
    logic       oe;
    cfg_t       lat;
  } seq_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  irm_cfg_if cfg_bus ();
  irm_req_if req_bus ();
  irm_res_if res_bus ();

  i2c_register_access_master_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  req_t       req_backlog[$];
  res_t       pin_reports_due[$];
  seq_state_t live_seq, plan_seq;
  cfg_t       live_cfg, plan_cfg;
  bit         req_taken = 1'b0;
  bit         cfg_taken = 1'b0;
  bit         calm = 1'b0;
  int         cycles = 0;
  int         errors = 0;
  int         queued_items = 0;
  int         results_seen = 0;
  int         txns_ended = 0;
  int         txns_nacked = 0;
  int         bytes_read = 0;

  function automatic seq_state_t seq_reset();
    seq_state_t s;
    s = '0;
    s.st = ST_IDLE;
    s.role = ROLE_DEV;
    s.scl = 1'b1;
    s.sda = 1'b1;
    s.oe = 1'b1;
    return s;
  endfunction

  function automatic void apply_reg(inout cfg_t c, input reg_idx_e idx, input logic [7:0] v);
    case (idx)
      REG_OP_IS_WRITE:    c.op_is_write = v[0];
      REG_BUS_SELECT:     c.bus_select = v[2:0];
      REG_DEVICE_ADDRESS: c.device_address = v;
      REG_REGISTER_ADDR:  c.register_address = v;
      REG_BYTE_COUNT:     c.byte_count = v;
      REG_RECOVERY_LIMIT: c.recovery_pulse_limit = v;
      default: ;
    endcase
  endfunction

  // one pin action of the master; returns the levels reported for this request
  function automatic res_t i2c_advance(inout seq_state_t s, input cfg_t c, input req_t r);
    res_t o;
    o = '0;
    case (r.kind)
      KIND_START: begin
        if (s.st == ST_IDLE && int'(c.bus_select) < NUM_BUSES) begin
          s.lat = c;
          s.n_done = '0;
          s.rec_cnt = '0;
          s.bit_idx = '0;
          s.oe = 1'b1;
          s.st = ST_RST_SCL;
        end
      end
      KIND_WBYTE: begin
        s.held = r.write_byte;
        s.have = 1'b1;
      end
      KIND_TICK: begin
        case (s.st)
          ST_RST_SCL: begin
            s.scl = 1'b1;
            s.st = ST_RST_SDA;
          end
          ST_RST_SDA: begin
            s.sda = 1'b1;
            s.st = ST_RST_REL;
          end
          ST_RST_REL: begin
            s.oe = 1'b0;
            s.st = ST_RST_CHECK;
          end
          ST_RST_CHECK: begin
            if (!r.sda_sample && s.rec_cnt < s.lat.recovery_pulse_limit && s.rec_cnt != '1) begin
              s.scl = 1'b0;
              s.rec_cnt = s.rec_cnt + 8'd1;
              s.st = ST_RST_HIGH;
            end else begin
              s.oe = 1'b1;
              s.st = ST_START_SDA;
            end
          end
          ST_RST_HIGH: begin
            s.scl = 1'b1;
            s.st = ST_RST_CHECK;
          end
          ST_START_SDA: begin
            s.sda = 1'b0;
            s.st = ST_START_SCL;
          end
          ST_START_SCL: begin
            s.scl = 1'b0;
            s.shreg = s.lat.device_address;
            s.bit_idx = 3'd7;
            s.role = ROLE_DEV;
            s.st = ST_BIT_SDA;
          end
          ST_BIT_SDA: begin
            s.sda = |(s.shreg & (8'd1 << s.bit_idx));
            s.st = ST_BIT_HI;
          end
          ST_BIT_HI: begin
            s.scl = 1'b1;
            s.st = ST_BIT_LO;
          end
          ST_BIT_LO: begin
            s.scl = 1'b0;
            if (s.bit_idx == 3'd0) begin
              s.st = ST_ACK_REL;
            end else begin
              s.bit_idx = s.bit_idx - 3'd1;
              s.st = ST_BIT_SDA;
            end
          end
          ST_ACK_REL: begin
            s.oe = 1'b0;
            s.st = ST_ACK_SDA;
          end
          ST_ACK_SDA: begin
            s.sda = 1'b1;
            s.st = ST_ACK_HI;
          end
          ST_ACK_HI: begin
            s.scl = 1'b1;
            s.st = ST_ACK_SAMPLE;
          end
          ST_ACK_SAMPLE: begin
            s.scl = 1'b0;
            s.st = r.sda_sample ? ST_ACK_FAIL : ST_ACK_OK;
          end
          ST_ACK_OK: begin
            s.oe = 1'b1;
            if (s.role == ROLE_DEV) begin
              s.shreg = s.lat.register_address;
              s.bit_idx = 3'd7;
              s.role = ROLE_REG;
              s.st = ST_BIT_SDA;
            end else if (s.role == ROLE_RADDR) begin
              s.st = ST_IN_REL;
            end else begin
              if (s.role == ROLE_WDATA) s.n_done = s.n_done + 8'd1;
              if (s.n_done >= s.lat.byte_count) s.st = ST_STOP_SDA;
              else if (s.lat.op_is_write) s.st = ST_WAIT_BYTE;
              else s.st = ST_REP_SDA1;
            end
          end
          ST_ACK_FAIL: begin
            s.oe = 1'b1;
            o.done_res = 1'b1;
            o.no_ack_error = 1'b1;
            s.st = ST_IDLE;
          end
          ST_WAIT_BYTE: begin
            if (s.have) begin
              s.shreg = s.held;
              s.bit_idx = 3'd7;
              s.role = ROLE_WDATA;
              s.have = 1'b0;
              s.sda = s.held[7];
              s.st = ST_BIT_HI;
            end
          end
          ST_REP_SDA1: begin
            s.sda = 1'b1;
            s.st = ST_REP_SCL1;
          end
          ST_REP_SCL1: begin
            s.scl = 1'b1;
            s.st = ST_REP_SDA0;
          end
          ST_REP_SDA0: begin
            s.sda = 1'b0;
            s.st = ST_REP_SCL0;
          end
          ST_REP_SCL0: begin
            s.scl = 1'b0;
            s.shreg = s.lat.device_address | 8'd1;
            s.bit_idx = 3'd7;
            s.role = ROLE_RADDR;
            s.st = ST_BIT_SDA;
          end
          ST_IN_REL: begin
            s.oe = 1'b0;
            s.st = ST_IN_SDA;
          end
          ST_IN_SDA: begin
            s.sda = 1'b1;
            s.bit_idx = 3'd7;
            s.shreg = '0;
            s.st = ST_IN_HI;
          end
          ST_IN_HI: begin
            s.scl = 1'b1;
            s.st = ST_IN_SAMPLE;
          end
          ST_IN_SAMPLE: begin
            if (r.sda_sample) s.shreg = s.shreg | (8'd1 << s.bit_idx);
            s.scl = 1'b0;
            if (s.bit_idx == 3'd0) begin
              s.st = ST_IN_DRIVE;
            end else begin
              s.bit_idx = s.bit_idx - 3'd1;
              s.st = ST_IN_HI;
            end
          end
          ST_IN_DRIVE: begin
            s.oe = 1'b1;
            o.read_valid = 1'b1;
            o.read_byte = s.shreg;
            s.n_done = s.n_done + 8'd1;
            s.st = (s.n_done >= s.lat.byte_count) ? ST_STOP_SDA : ST_REP_SDA1;
          end
          ST_STOP_SDA: begin
            s.sda = 1'b0;
            s.st = ST_STOP_SCL;
          end
          ST_STOP_SCL: begin
            s.scl = 1'b1;
            s.st = ST_STOP_END;
          end
          ST_STOP_END: begin
            s.sda = 1'b1;
            o.done_res = 1'b1;
            s.st = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.scl_level = s.scl;
    o.sda_level = s.sda;
    o.drive_enable = s.oe;
    o.target_bus = s.lat.bus_select;
    o.need_write_byte = (s.st == ST_WAIT_BYTE) && !s.have;
    o.busy_res = (s.st != ST_IDLE);
    return o;
  endfunction

  function automatic req_t mk(input logic [1:0] kind, input logic sda);
    req_t r;
    r.kind = kind;
    r.sda_sample = sda;
    r.write_byte = 8'($urandom);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin : drv
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      res_bus.ready <= 1'b0;
    end else begin
      if (req_taken) void'(req_backlog.pop_front());
      if (!req_bus.valid || req_taken) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          req_bus.valid <= 1'b1;
          req_bus.kind <= req_backlog[0].kind;
          req_bus.sda_sample <= req_backlog[0].sda_sample;
          req_bus.write_byte <= req_backlog[0].write_byte;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      res_bus.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk_i) begin : mon
    res_t want;
    req_t item;
    if (rst_ni) begin
      req_taken = req_bus.valid && req_bus.ready;
      cfg_taken = cfg_bus.valid && cfg_bus.ready;
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (pin_reports_due.size() == 0) begin
          $display("%0t: result arrived with no request outstanding", $time);
          errors++;
        end else begin
          want = pin_reports_due.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(res_bus.scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(res_bus.sda_level));
          check_field("drive_enable", 8'(want.drive_enable), 8'(res_bus.drive_enable));
          check_field("target_bus", 8'(want.target_bus), 8'(res_bus.target_bus));
          check_field("read_byte", want.read_byte, res_bus.read_byte);
          check_field("read_valid", 8'(want.read_valid), 8'(res_bus.read_valid));
          check_field("need_write_byte", 8'(want.need_write_byte), 8'(res_bus.need_write_byte));
          check_field("busy_res", 8'(want.busy_res), 8'(res_bus.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(res_bus.done_res));
          check_field("no_ack_error", 8'(want.no_ack_error), 8'(res_bus.no_ack_error));
        end
        if (res_bus.done_res) txns_ended++;
        if (res_bus.done_res && res_bus.no_ack_error) txns_nacked++;
        if (res_bus.read_valid) bytes_read++;
      end
      if (cfg_taken) apply_reg(live_cfg, reg_idx_e'(cfg_bus.index), cfg_bus.data);
      if (req_taken) begin
        item.kind = req_bus.kind;
        item.sda_sample = req_bus.sda_sample;
        item.write_byte = req_bus.write_byte;
        pin_reports_due.push_back(i2c_advance(live_seq, live_cfg, item));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("%0t: run timed out", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_req(input req_t r);
    void'(i2c_advance(plan_seq, plan_cfg, r));
    req_backlog.push_back(r);
    queued_items++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_bus.valid <= 1'b0;
    apply_reg(plan_cfg, idx, val);
  endtask

  task automatic program_all(input cfg_t c);
    logic [7:0] pad;
    pad = 8'($urandom);
    write_reg(REG_OP_IS_WRITE, {pad[7:1], c.op_is_write});
    write_reg(REG_BUS_SELECT, {pad[7:3], c.bus_select});
    write_reg(REG_DEVICE_ADDRESS, c.device_address);
    write_reg(REG_REGISTER_ADDR, c.register_address);
    write_reg(REG_BYTE_COUNT, c.byte_count);
    write_reg(REG_RECOVERY_LIMIT, c.recovery_pulse_limit);
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || pin_reports_due.size() != 0 || req_bus.valid)
      @(negedge clk_i);
  endtask

  // one start plus the requests that end it; nack_at counts slave acks from 1
  task automatic run_txn(input int pulses, input int nack_at, input int noise_pct);
    int acks;
    int low_left;
    logic [1:0] k;
    acks = 0;
    low_left = pulses;
    push_req(mk(KIND_START, 1'($urandom)));
    while (plan_seq.st != ST_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0: k = KIND_NONE;
          1: k = KIND_START;
          default: k = KIND_WBYTE;
        endcase
        push_req(mk(k, 1'($urandom)));
      end else begin
        case (plan_seq.st)
          ST_RST_CHECK: begin
            push_req(mk(KIND_TICK, low_left == 0));
            if (low_left > 0) low_left--;
          end
          ST_ACK_SAMPLE: begin
            acks++;
            push_req(mk(KIND_TICK, acks == nack_at));
          end
          ST_WAIT_BYTE: begin
            if (!plan_seq.have && $urandom_range(0, 3) != 0) push_req(mk(KIND_WBYTE, 1'($urandom)));
            else push_req(mk(KIND_TICK, 1'($urandom)));
          end
          default: push_req(mk(KIND_TICK, 1'($urandom)));
        endcase
      end
    end
  endtask

  initial begin : stim
    req_t r;
    cfg_t c;
    int phase;
    int pick;
    int nack_at;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_OP_IS_WRITE;
    cfg_bus.data = '0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_TICK;
    req_bus.sda_sample = 1'b0;
    req_bus.write_byte = '0;
    res_bus.ready = 1'b0;
    live_seq = seq_reset();
    plan_seq = seq_reset();
    live_cfg = '0;
    live_cfg.recovery_pulse_limit = RECOVERY_DEFAULT;
    plan_cfg = live_cfg;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // idle ticks, unused kind, a held byte replaced by another
    push_req(mk(KIND_TICK, 1'b0));
    push_req(mk(KIND_TICK, 1'b1));
    push_req(mk(KIND_NONE, 1'b1));
    r = mk(KIND_WBYTE, 1'b0);
    r.write_byte = 8'h00;
    push_req(r);
    r.write_byte = 8'hFF;
    push_req(r);
    run_txn(2, 0, 0);
    drain();

    // starts on buses that do not exist
    program_all(cfg_t'{1'b0, 3'd6, 8'h00, 8'h00, 8'd0, 8'd3});
    run_txn(0, 0, 0);
    drain();
    write_reg(REG_BUS_SELECT, 8'hFF);
    run_txn(0, 0, 0);
    drain();

    // write using the held byte, zero recovery limit, stray requests mid transfer
    program_all(cfg_t'{1'b1, 3'd5, 8'hFF, 8'h00, 8'd2, 8'd0});
    run_txn(3, 0, 10);
    drain();

    // stuck sda saturates the recovery counter
    program_all(cfg_t'{1'b0, 3'd3, 8'h00, 8'hFF, 8'd2, 8'd255});
    run_txn(300, 0, 0);
    drain();

    // missing acks on address, register and data phases
    program_all(cfg_t'{1'b1, 3'd1, 8'h5A, 8'hA5, 8'd255, 8'd4});
    run_txn(1, 1, 0);
    run_txn(0, 4, 0);
    drain();
    program_all(cfg_t'{1'b0, 3'd2, 8'h3C, 8'hC3, 8'd255, 8'd1});
    run_txn(5, 2, 0);
    run_txn(0, 4, 0);
    drain();

    phase = 0;
    while (queued_items < RANDOM_ITEMS) begin
      c.op_is_write = 1'($urandom);
      c.bus_select = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
      c.device_address = 8'($urandom);
      c.register_address = 8'($urandom);
      pick = $urandom_range(0, 9);
      c.byte_count = (pick < 7) ? 8'($urandom_range(0, 2)) :
                     (pick < 9) ? 8'($urandom_range(3, 4)) : 8'd255;
      pick = $urandom_range(0, 9);
      c.recovery_pulse_limit = (pick < 6) ? 8'($urandom_range(0, 4)) :
                               (pick < 9) ? 8'($urandom_range(5, 20)) : 8'd255;
      program_all(c);
      calm = (phase >= 3 && phase < 6);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 9) < 3) push_req(mk(KIND_WBYTE, 1'($urandom)));
        repeat ($urandom_range(0, 2)) push_req(mk(KIND_TICK, 1'($urandom)));
        if (c.byte_count > 8'd6) nack_at = $urandom_range(3, 5);
        else if ($urandom_range(0, 99) < 15) nack_at = $urandom_range(1, 2 + int'(c.byte_count));
        else nack_at = 0;
        run_txn(($urandom_range(0, 4) == 0) ? 8 : $urandom_range(0, 3), nack_at, 4);
      end
      drain();
      phase++;
    end
    calm = 1'b0;

    drain();
    repeat (6) @(negedge clk_i);
    $display("checked %0d pin reports across %0d finished transfers", results_seen, txns_ended);
    $display("%0d transfers ended on a missing ack, %0d bytes read back", txns_nacked,
             bytes_read);
    if (errors == 0 && pin_reports_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
